// ===== hdl/h264_nal_start_code_splitter_top_assert.svh =====
// ----------------------------------------------------------------------------
// NAL splitter assertion macros
// Shared property forms for the start code splitter checks.
// ----------------------------------------------------------------------------
`ifndef H264_NAL_START_CODE_SPLITTER_TOP_ASSERT_SVH
`define H264_NAL_START_CODE_SPLITTER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define NSCS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nal splitter check failed");

// next-cycle implication, disabled during reset
`define NSCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nal splitter check failed");

`endif

// ===== hdl/nscs_pkg.sv =====
// ----------------------------------------------------------------------------
// NAL splitter package
// Payload types, queue entry type and size limits.
// ----------------------------------------------------------------------------
package nscs_pkg;

  localparam int MAX_NAL_BYTES = 65536;
  localparam int PAYLOAD_LIMIT_INT =
    ((MAX_NAL_BYTES - 4) > 65535) ? 65535 : (MAX_NAL_BYTES - 4);
  localparam logic [15:0] PAYLOAD_LIMIT = 16'(PAYLOAD_LIMIT_INT);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [4:0] NAL_TYPE_SLICE = 5'd1;
  localparam logic [4:0] NAL_TYPE_IDR   = 5'd5;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  nal_byte;
    logic        first_of_nal;
    logic        last_of_nal;
    logic [4:0]  nal_type;
    logic        is_slice;
    logic        is_keyframe;
    logic [15:0] nal_length;
  } nal_t;

  // work for the back end: keep bytes in order, then optionally close
  typedef struct packed {
    logic [1:0]      keep_count;
    logic            close;
    logic [2:0][7:0] bytes;
  } op_t;

endpackage

// ===== hdl/nscs_front.sv =====
// ----------------------------------------------------------------------------
// NAL splitter front end
// Lookahead window and start code detection; emits keep/close work entries.
// ----------------------------------------------------------------------------
module nscs_front
  import nscs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  output logic  push,
  output op_t   push_op,
  input  logic  full
);

  logic [2:0][7:0] window;
  logic [1:0]      fill;
  logic            inside_nal;

  logic accept;
  logic match;
  logic op_any;

  assign item_stall = full;
  assign accept     = item_valid && !full;

  always_comb begin
    case (fill)
      2'd2:    match = (window[0] == 8'h00) && (window[1] == 8'h00);
      2'd3:    match = (window[1] == 8'h00) && (window[2] == 8'h00);
      default: match = 1'b0;
    endcase
    match = match && (item.data_byte == 8'h01);
  end

  always_comb begin
    push_op            = '0;
    push_op.bytes      = window;
    if (item.cmd == CMD_FLUSH) begin
      push_op.keep_count = inside_nal ? fill : 2'd0;
      push_op.close      = inside_nal;
    end else if (match) begin
      push_op.keep_count = (inside_nal && (fill == 2'd3) && (window[0] != 8'h00)) ?
                           2'd1 : 2'd0;
      push_op.close      = inside_nal;
    end else if (fill == 2'd3) begin
      push_op.keep_count = inside_nal ? 2'd1 : 2'd0;
    end
  end

  assign op_any = (push_op.keep_count != 2'd0) || push_op.close;
  assign push   = accept && op_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= 2'd0;
      inside_nal <= 1'b0;
    end else if (accept) begin
      if (item.cmd == CMD_FLUSH) begin
        fill       <= 2'd0;
        inside_nal <= 1'b0;
      end else if (match) begin
        fill       <= 2'd0;
        inside_nal <= 1'b1;
      end else if (fill != 2'd3) begin
        fill <= fill + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (item.cmd == CMD_DATA) && !match) begin
      if (fill == 2'd3) begin
        window[0] <= window[1];
        window[1] <= window[2];
        window[2] <= item.data_byte;
      end else begin
        window[fill] <= item.data_byte;
      end
    end
  end

endmodule

// ===== hdl/nscs_queue.sv =====
// ----------------------------------------------------------------------------
// NAL splitter work queue
// Short FIFO of work entries between front and back ends.
// ----------------------------------------------------------------------------
module nscs_queue
  import nscs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  output logic pop_valid,
  output op_t  pop_op,
  input  logic pop
);

  op_t                    entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  logic do_push;
  logic do_pop;

  assign full      = (count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_op    = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

// ===== hdl/nscs_back.sv =====
// ----------------------------------------------------------------------------
// NAL splitter back end
// Steps through work entries, holds the newest kept byte, drives results.
// ----------------------------------------------------------------------------
module nscs_back
  import nscs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic pop_valid,
  input  op_t  pop_op,
  output logic pop,
  output logic nal_valid,
  input  logic nal_stall,
  output nal_t nal
);

  `include "h264_nal_start_code_splitter_top_assert.svh"

  logic [7:0]  held_byte;
  logic        held_valid;
  logic [15:0] payload_count;
  logic [4:0]  current_type;
  logic [1:0]  idx;

  logic        out_free;
  logic        step;
  logic        is_keep;
  logic        room;
  logic        emit;
  logic        done;
  logic [7:0]  sel_byte;
  nal_t        result;

  assign out_free = !nal_valid || !nal_stall;
  assign step     = pop_valid && out_free;
  assign is_keep  = (idx < pop_op.keep_count);
  assign room     = (payload_count < PAYLOAD_LIMIT);
  assign emit     = step && held_valid && (!is_keep || room);
  assign done     = is_keep ? (((idx + 2'd1) == pop_op.keep_count) && !pop_op.close) : 1'b1;
  assign pop      = step && done;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = pop_op.bytes[0];
      2'd1:    sel_byte = pop_op.bytes[1];
      2'd2:    sel_byte = pop_op.bytes[2];
      default: sel_byte = 8'h00;
    endcase
  end

  always_comb begin
    result.nal_byte     = held_byte;
    result.first_of_nal = (payload_count == 16'd1);
    result.last_of_nal  = !is_keep;
    result.nal_type     = current_type;
    result.is_slice     = (current_type == NAL_TYPE_SLICE) || (current_type == NAL_TYPE_IDR);
    result.is_keyframe  = (current_type == NAL_TYPE_IDR);
    result.nal_length   = payload_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid    <= 1'b0;
      payload_count <= 16'd0;
      current_type  <= 5'd0;
      idx           <= 2'd0;
    end else if (step) begin
      idx <= done ? 2'd0 : idx + 2'd1;
      if (is_keep) begin
        if (room) begin
          held_valid    <= 1'b1;
          payload_count <= payload_count + 16'd1;
          if (payload_count == 16'd0) begin
            current_type <= sel_byte[4:0];
          end
        end
      end else begin
        held_valid    <= 1'b0;
        payload_count <= 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && is_keep && room) begin
      held_byte <= sel_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nal_valid <= 1'b0;
    end else if (out_free) begin
      nal_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      nal <= result;
    end
  end

  `NSCS_ASSERT_NOW(a_count_limit, clk, rst, 1'b1, payload_count <= PAYLOAD_LIMIT)
  `NSCS_ASSERT_NOW(a_held_counted, clk, rst, held_valid, payload_count != 16'd0)
  `NSCS_ASSERT_NOW(a_idx_range, clk, rst, pop_valid, idx <= pop_op.keep_count)
  `NSCS_ASSERT_NEXT(a_first_len, clk, rst, emit && (payload_count == 16'd1),
                    nal.first_of_nal && (nal.nal_length == 16'd1))

endmodule

// ===== hdl/h264_nal_start_code_splitter_top.sv =====
// ----------------------------------------------------------------------------
// H.264 Annex B NAL start code splitter
// Splits a byte stream at 00 00 01 start codes into marked NAL payload bytes.
// ----------------------------------------------------------------------------
//  channel | valid      | stall      | payload
//  input   | item_valid | item_stall | item (cmd, data_byte)
//  output  | nal_valid  | nal_stall  | nal (byte, marks, type, flags, length)
//
// One input byte per cycle is accepted while the four-entry work queue has room.
// The back end steps through each work entry one kept byte or one NAL close at a
// time while the output register is free; a flush keeps up to three bytes, then closes.
// Results leave through one output register, one per cycle at most.
// Reset is synchronous and clears window fill, NAL state, queue and output valid.
// A stall on the output holds the back end; the queue then fills and stalls input.
module h264_nal_start_code_splitter_top
  import nscs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  output logic  nal_valid,
  input  logic  nal_stall,
  output nal_t  nal
);

  logic push;
  op_t  push_op;
  logic full;
  logic pop_valid;
  op_t  pop_op;
  logic pop;

  nscs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .push_op    (push_op),
    .full       (full)
  );

  nscs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (full),
    .pop_valid (pop_valid),
    .pop_op    (pop_op),
    .pop       (pop)
  );

  nscs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_op    (pop_op),
    .pop       (pop),
    .nal_valid (nal_valid),
    .nal_stall (nal_stall),
    .nal       (nal)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NAL start code splitter testbench
// Feeds an Annex B byte stream into the splitter and predicts every NAL
// payload byte, its first and last marks, type, slice and keyframe flags and
// running length. The stream holds a short hand-built section and random units
// with start code and zero run variants.
// Both channels idle and stall at random. Each output transaction is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import nscs_pkg::*;

  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;
  localparam int RANDOM_ITEMS  = 300;
  localparam int IDLE_LIMIT    = 4000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 120;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  item_valid = 1'b0;
  logic  item_stall;
  item_t item = '0;
  logic  nal_valid;
  logic  nal_stall = 1'b0;
  nal_t  nal;

  item_t pending_items[$];
  nal_t  expected_nals[$];

  logic [7:0]  window[3];
  int unsigned window_fill = 0;
  bit          in_unit = 1'b0;
  logic [7:0]  held_byte = '0;
  bit          held_ok = 1'b0;
  int unsigned kept_count = 0;
  logic [4:0]  unit_type = '0;

  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  int unsigned nal_count = 0;
  int unsigned unit_count = 0;
  int unsigned idle_cycles = 0;

  int unsigned tx_gap = 0;
  int unsigned tx_mode = 0;
  int unsigned tx_mode_left = 0;
  int unsigned rx_stall_left = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;

  h264_nal_start_code_splitter_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .nal_valid  (nal_valid),
    .nal_stall  (nal_stall),
    .nal        (nal)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic item_t data_item(input logic [7:0] b);
    item_t it;
    it.cmd = CMD_DATA;
    it.data_byte = b;
    return it;
  endfunction

  function automatic item_t flush_item();
    item_t it;
    it.cmd = CMD_FLUSH;
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  function automatic int unsigned pick_gap(input int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (mode == 0) begin
      return 0;
    end else if (mode == 1) begin
      if (r < 75) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(10, 30);
  endfunction

  function automatic nal_t unit_byte(input logic [7:0] b, input bit is_first, input bit is_last);
    nal_t n;
    n.nal_byte     = b;
    n.first_of_nal = is_first;
    n.last_of_nal  = is_last;
    n.nal_type     = unit_type;
    n.is_slice     = (unit_type == NAL_TYPE_SLICE) || (unit_type == NAL_TYPE_IDR);
    n.is_keyframe  = (unit_type == NAL_TYPE_IDR);
    n.nal_length   = kept_count[15:0];
    return n;
  endfunction

  task automatic keep_payload(input logic [7:0] b);
    if (!in_unit || kept_count >= PAYLOAD_LIMIT) return;
    if (held_ok) expected_nals.push_back(unit_byte(held_byte, kept_count == 1, 1'b0));
    if (kept_count == 0) unit_type = b[4:0];
    held_byte = b;
    held_ok = 1'b1;
    kept_count++;
  endtask

  task automatic close_unit();
    if (held_ok) expected_nals.push_back(unit_byte(held_byte, kept_count == 1, 1'b1));
    held_ok = 1'b0;
    kept_count = 0;
  endtask

  task automatic split_item(input item_t it);
    int unsigned fill;
    fill = window_fill;
    if (it.cmd == CMD_FLUSH) begin
      for (int i = 0; i < fill; i++) keep_payload(window[i]);
      close_unit();
      in_unit = 1'b0;
      window_fill = 0;
    end else if (fill >= 2 && window[fill-2] == SC_ZERO && window[fill-1] == SC_ZERO &&
                 it.data_byte == SC_ONE) begin
      if (fill == 3 && window[0] != SC_ZERO) keep_payload(window[0]);
      close_unit();
      in_unit = 1'b1;
      window_fill = 0;
    end else if (fill == 3) begin
      keep_payload(window[0]);
      window[0] = window[1];
      window[1] = window[2];
      window[2] = it.data_byte;
    end else begin
      window[fill] = it.data_byte;
      window_fill = fill + 1;
    end
  endtask

  // driver
  always @(posedge clk) begin
    bit busy;
    if (rst) begin
      item_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      busy = item_valid;
      if (item_valid && !item_stall) begin
        split_item(item);
        sent_count++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
          item_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
          if (tx_mode_left == 0) begin
            tx_mode = $urandom_range(0, 2);
            tx_mode_left = $urandom_range(20, 200);
          end
          tx_mode_left--;
          tx_gap = pick_gap(tx_mode);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    nal_t exp_nal;
    if (rst) begin
      nal_stall <= 1'b0;
    end else begin
      if (nal_valid && !nal_stall) begin
        nal_count++;
        if (expected_nals.size() == 0) begin
          $error("unexpected output transaction: byte %0h", nal.nal_byte);
          fail_count++;
        end else begin
          exp_nal = expected_nals.pop_front();
          if (nal !== exp_nal) begin
            fail_count++;
            if (nal.nal_byte !== exp_nal.nal_byte)
              $error("nal_byte: expected %0h, got %0h", exp_nal.nal_byte, nal.nal_byte);
            if (nal.first_of_nal !== exp_nal.first_of_nal)
              $error("first_of_nal: expected %0d, got %0d", exp_nal.first_of_nal,
                     nal.first_of_nal);
            if (nal.last_of_nal !== exp_nal.last_of_nal)
              $error("last_of_nal: expected %0d, got %0d", exp_nal.last_of_nal,
                     nal.last_of_nal);
            if (nal.nal_type !== exp_nal.nal_type)
              $error("nal_type: expected %0d, got %0d", exp_nal.nal_type, nal.nal_type);
            if (nal.is_slice !== exp_nal.is_slice)
              $error("is_slice: expected %0d, got %0d", exp_nal.is_slice, nal.is_slice);
            if (nal.is_keyframe !== exp_nal.is_keyframe)
              $error("is_keyframe: expected %0d, got %0d", exp_nal.is_keyframe,
                     nal.is_keyframe);
            if (nal.nal_length !== exp_nal.nal_length)
              $error("nal_length: expected %0d, got %0d", exp_nal.nal_length,
                     nal.nal_length);
          end
          if (exp_nal.last_of_nal) unit_count++;
        end
        // hold off long enough for the work queue to fill
        if ((nal_count % 20000) == 30) rx_hold_left = HOLD_CYCLES;
      end
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(20, 300);
      end
      rx_mode_left--;
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        nal_stall <= 1'b1;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        nal_stall <= 1'b1;
      end else begin
        nal_stall <= 1'b0;
        rx_stall_left = pick_gap(rx_mode);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (nal_valid && !nal_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[h264_nal_start_code_splitter_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned base;
    int unsigned r;
    int unsigned len;
    logic [7:0] b;

    // junk, IDR unit ending in a longer zero run, slice unit with a kept byte
    // ahead of the start code, empty unit, then flush with pending window
    pending_items.push_back(data_item(8'hAB));
    pending_items.push_back(data_item(SC_ZERO));
    pending_items.push_back(data_item(SC_ZERO));
    pending_items.push_back(data_item(SC_ONE));
    pending_items.push_back(data_item(8'h65));
    pending_items.push_back(data_item(8'hFF));
    pending_items.push_back(data_item(SC_ZERO));
    pending_items.push_back(data_item(SC_ZERO));
    pending_items.push_back(data_item(SC_ZERO));
    pending_items.push_back(data_item(SC_ONE));
    pending_items.push_back(data_item(8'h41));
    pending_items.push_back(data_item(8'h7F));
    pending_items.push_back(data_item(8'h80));
    pending_items.push_back(data_item(SC_ZERO));
    pending_items.push_back(data_item(SC_ZERO));
    pending_items.push_back(data_item(SC_ONE));
    pending_items.push_back(data_item(SC_ZERO));
    pending_items.push_back(data_item(SC_ZERO));
    pending_items.push_back(data_item(SC_ONE));
    pending_items.push_back(data_item(8'hE7));
    pending_items.push_back(data_item(SC_ONE));
    pending_items.push_back(flush_item());

    base = pending_items.size();
    while (pending_items.size() - base < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) pending_items.push_back(data_item(8'($urandom)));
      end else if (r < 14) begin
        pending_items.push_back(flush_item());
      end else begin
        if ($urandom_range(0, 1) == 1) pending_items.push_back(data_item(SC_ZERO));
        pending_items.push_back(data_item(SC_ZERO));
        pending_items.push_back(data_item(SC_ZERO));
        pending_items.push_back(data_item(SC_ONE));
        if ($urandom_range(0, 9) != 0) begin
          b = 8'($urandom);
          if ($urandom_range(0, 9) < 4)
            b[4:0] = $urandom_range(0, 1) ? NAL_TYPE_SLICE : NAL_TYPE_IDR;
          pending_items.push_back(data_item(b));
        end
        len = $urandom_range(0, 10);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 99);
          if (r < 30) b = SC_ZERO;
          else if (r < 40) b = SC_ONE;
          else b = 8'($urandom);
          pending_items.push_back(data_item(b));
        end
        if ($urandom_range(0, 9) < 2) pending_items.push_back(flush_item());
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || item_valid) @(posedge clk);
    while (expected_nals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d input transactions, checked %0d output transactions in %0d NAL units,",
             sent_count, nal_count, unit_count);
    $display("including start code variants, zero runs, empty units and flushes.");
    if (fail_count == 0) begin
      $display("[h264_nal_start_code_splitter_top] OK");
    end else begin
      $display("[h264_nal_start_code_splitter_top] ERROR");
    end
    $finish;
  end

endmodule
